// ----- design/ftmn_pkg.sv -----
package ftmn_pkg;

  localparam int unsigned NODES = 16;
  localparam int unsigned IDX_W = $clog2(NODES);
  localparam int unsigned CNT_W = $clog2(NODES + 1);
  localparam int unsigned TALLY_W = 4;
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    CFG_OWN_ID     = 2'd0,
    CFG_NODE_TOTAL = 2'd1,
    CFG_STARTS_FORK = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_MSG     = 2'd0,
    ACT_ENTER   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MSG_REQUEST = 2'd0,
    MSG_RELEASE = 2'd1,
    MSG_DONE    = 2'd2,
    MSG_STARTED = 2'd3
  } msg_kind_e;

  typedef enum logic [1:0] {
    FORK_ABSENT = 2'd0,
    FORK_CLEAN  = 2'd1,
    FORK_DIRTY  = 2'd2
  } fork_e;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_BCAST   = 2'd1,
    SEND_RELEASE = 2'd2
  } send_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] message_kind;
    logic [3:0] sender_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] send_kind;
    logic [3:0] send_target;
    logic       section_granted;
    logic [1:0] fork_now;
    logic [3:0] done_seen;
    logic [3:0] started_seen;
    logic       misuse_error;
  } result_t;

  typedef struct packed {
    logic set;
    logic clr;
    logic clr_all;
    logic load;
    logic sel;
    logic shift;
    logic last;
  } cell_ctl_t;

endpackage

// ----- design/ftmn_cell.sv -----
module ftmn_cell
  import ftmn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      tok_i,
  output logic      tok_fwd_o,
  output logic      tok_wrap_o,
  output logic      hit_o
);

  logic pend_q, pend_d;
  logic tok_q, tok_d;

  always_comb begin
    pend_d = pend_q;
    if (ctl_i.clr_all) begin
      pend_d = 1'b0;
    end else if (ctl_i.set) begin
      pend_d = 1'b1;
    end else if (ctl_i.clr) begin
      pend_d = 1'b0;
    end
    tok_d = tok_q;
    if (ctl_i.load) begin
      tok_d = ctl_i.sel;
    end else if (ctl_i.shift) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_fwd_o  = tok_q & ~ctl_i.last;
  assign tok_wrap_o = tok_q & ctl_i.last;
  assign hit_o      = tok_q & pend_q;

endmodule

// ----- design/fork_token_mutex_node_top.sv -----
// Fork token mutual exclusion node.
// Items enter on start_i/in_item_i; a transfer happens when start_i is high
// and busy_o is low. Exactly one result follows each item on result_o, marked
// by result_valid_o for one cycle; the receiver cannot stall it.
// Messages, enter requests, misused releases and unknown actions: result in the
// cycle after the transfer, next item may follow at once.
// A release holding a clean fork runs the round-robin search: it reduces
// own_node_id modulo the node count (one subtract per cycle), places a token,
// then walks the token round a ring of request cells, visiting at most 16
// nodes. With a node count of zero it ends without a search. busy_o drops in
// the cycle that carries the result strobe.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, write only while the node is idle. Writing the
// starts-with-fork register also reloads the fork state.
// Reset: own id 0, two nodes, fork absent, no requests, tallies zero.
module fork_token_mutex_node_top
  import ftmn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  in_item_t              in_item_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output result_t               result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e               state_q, state_d;
  fork_e                fork_q, fork_d;
  logic [TALLY_W-1:0]   dtally_q, dtally_d;
  logic [TALLY_W-1:0]   stally_q, stally_d;
  logic [IDX_W-1:0]     own_q;
  logic [CNT_W-1:0]     total_q;
  logic [IDX_W-1:0]     start_q, start_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  result_t              res_q, res_d;
  logic                 vld_q, vld_d;

  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     n_last;
  logic                 set_en, clr_en, clr_all, load, shift, fin;
  logic [1:0]           send_kind;
  logic [3:0]           send_target;
  logic                 misuse;
  logic                 cfg_wr;

  cell_ctl_t            ctl [NODES];
  logic [NODES-1:0]     tok_in, tok_fwd, tok_wrap, hit;

  assign n_eff  = (total_q > CNT_W'(NODES)) ? CNT_W'(NODES) : total_q;
  assign n_last = n_eff - CNT_W'(1);
  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i & cfg_ready_o;

  always_comb begin
    state_d     = state_q;
    fork_d      = fork_q;
    dtally_d    = dtally_q;
    stally_d    = stally_q;
    start_d     = start_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    vld_d       = 1'b0;
    set_en      = 1'b0;
    clr_en      = 1'b0;
    clr_all     = 1'b0;
    load        = 1'b0;
    shift       = 1'b0;
    fin         = 1'b0;
    send_kind   = SEND_NONE;
    send_target = '0;
    misuse      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          fin = 1'b1;
          case (in_item_i.action)
            ACT_MSG: begin
              case (in_item_i.message_kind)
                MSG_REQUEST: begin
                  if (fork_q == FORK_DIRTY) begin
                    fork_d      = FORK_ABSENT;
                    send_kind   = SEND_RELEASE;
                    send_target = in_item_i.sender_id;
                  end else begin
                    set_en = 1'b1;
                  end
                end
                MSG_RELEASE: fork_d = FORK_CLEAN;
                MSG_DONE: begin
                  clr_en = 1'b1;
                  if (dtally_q != TALLY_MAX) dtally_d = dtally_q + TALLY_W'(1);
                end
                MSG_STARTED: begin
                  if (stally_q != TALLY_MAX) stally_d = stally_q + TALLY_W'(1);
                end
                default: ;
              endcase
            end
            ACT_ENTER: begin
              fork_d = (fork_q == FORK_DIRTY) ? FORK_CLEAN : fork_q;
              if (fork_d != FORK_CLEAN) send_kind = SEND_BCAST;
            end
            ACT_RELEASE: begin
              if (fork_q != FORK_CLEAN) begin
                misuse = 1'b1;
              end else begin
                fin     = 1'b0;
                fork_d  = FORK_DIRTY;
                start_d = own_q;
                state_d = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (n_eff == '0) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else if ({1'b0, start_q} >= n_eff) begin
          start_d = IDX_W'({1'b0, start_q} - n_eff);
        end else begin
          load    = 1'b1;
          idx_d   = start_q;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (|hit) begin
          clr_all     = 1'b1;
          fork_d      = FORK_ABSENT;
          send_kind   = SEND_RELEASE;
          send_target = idx_q;
          fin         = 1'b1;
          state_d     = ST_IDLE;
        end else if ({1'b0, cnt_q} == n_last) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          shift = 1'b1;
          idx_d = ({1'b0, idx_q} == n_last) ? '0 : idx_q + IDX_W'(1);
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (fin) begin
      vld_d                 = 1'b1;
      res_d.send_kind       = send_kind;
      res_d.send_target     = send_target;
      res_d.section_granted = (fork_d == FORK_CLEAN);
      res_d.fork_now        = fork_d;
      res_d.done_seen       = dtally_d;
      res_d.started_seen    = stally_d;
      res_d.misuse_error    = misuse;
    end
    if (cfg_wr && cfg_index_i == CFG_STARTS_FORK) begin
      fork_d = cfg_data_i[0] ? FORK_DIRTY : FORK_ABSENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fork_q   <= FORK_ABSENT;
      dtally_q <= '0;
      stally_q <= '0;
      own_q    <= '0;
      total_q  <= CNT_W'(2);
      start_q  <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      fork_q   <= fork_d;
      dtally_q <= dtally_d;
      stally_q <= stally_d;
      start_q  <= start_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      vld_q    <= vld_d;
      if (cfg_wr && cfg_index_i == CFG_OWN_ID) own_q <= cfg_data_i[IDX_W-1:0];
      if (cfg_wr && cfg_index_i == CFG_NODE_TOTAL) total_q <= cfg_data_i[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = vld_q;
  assign result_o       = res_q;

  for (genvar k = 0; k < NODES; k++) begin : g_cell
    always_comb begin
      ctl[k].set     = set_en && (in_item_i.sender_id == IDX_W'(k));
      ctl[k].clr     = clr_en && (in_item_i.sender_id == IDX_W'(k));
      ctl[k].clr_all = clr_all;
      ctl[k].load    = load;
      ctl[k].sel     = (start_q == IDX_W'(k));
      ctl[k].shift   = shift;
      ctl[k].last    = (n_last == CNT_W'(k));
    end
    if (k == 0) begin : g_head
      assign tok_in[k] = tok_fwd[NODES-1] | (|tok_wrap);
    end else begin : g_body
      assign tok_in[k] = tok_fwd[k-1];
    end
    ftmn_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl[k]),
      .tok_i      (tok_in[k]),
      .tok_fwd_o  (tok_fwd[k]),
      .tok_wrap_o (tok_wrap[k]),
      .hit_o      (hit[k])
    );
  end

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobed while busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (result_valid_o || state_q == ST_MOD))
    else $error("accepted item neither finished nor searching");

  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> $onehot(tok_fwd | tok_wrap))
    else $error("search token lost or duplicated");

  a_scan_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_MOD) |-> (fork_q == FORK_DIRTY))
    else $error("fork not dirty during search");

  a_pass_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && (|hit)) |=> (result_valid_o && hit == '0 &&
      result_o.send_kind == SEND_RELEASE))
    else $error("fork pass did not complete");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ftmn_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 153;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    in_item_t              item;
    bit                    pinned;
    result_t               res;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  in_item_t              in_item_i;
  logic                  busy_o;
  logic                  result_valid_o;
  result_t               result_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // node model
  logic [IDX_W-1:0]   own_id = '0;
  logic [4:0]         node_cnt = 5'd2;
  logic               starts_fork = 1'b0;
  fork_e              fork_st = FORK_ABSENT;
  logic [NODES-1:0]   req_bits = '0;
  logic [TALLY_W-1:0] done_cnt = '0;
  logic [TALLY_W-1:0] started_cnt = '0;

  result_t  pending_results[$];
  result_t  want;
  result_t  got;
  bit       pin_on = 1'b0;
  result_t  pin_res = '0;
  int unsigned err_cnt = 0;
  int unsigned n_items = 0;
  int unsigned n_pass = 0;
  int unsigned n_bcast = 0;
  int unsigned n_misuse = 0;
  int unsigned n_cfg = 0;

  fork_token_mutex_node_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_item_i      (in_item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic result_t mk_res(input send_kind_e sk, input logic [3:0] tgt,
                                     input logic grant, input fork_e fk,
                                     input logic [3:0] dn, input logic [3:0] st,
                                     input logic misuse);
    result_t r;
    r.send_kind       = sk;
    r.send_target     = tgt;
    r.section_granted = grant;
    r.fork_now        = fk;
    r.done_seen       = dn;
    r.started_seen    = st;
    r.misuse_error    = misuse;
    return r;
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] act, input logic [1:0] kind,
                                       input logic [3:0] sender);
    in_item_t it;
    it.action       = act;
    it.message_kind = kind;
    it.sender_id    = sender;
    return it;
  endfunction

  function automatic dir_row_t row_item(input in_item_t it);
    dir_row_t r;
    r = '{default: '0};
    r.item = it;
    return r;
  endfunction

  function automatic dir_row_t row_pin(input in_item_t it, input result_t res);
    dir_row_t r;
    r = row_item(it);
    r.pinned = 1'b1;
    r.res    = res;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // advances the node model by one event and returns its outcome
  function automatic result_t step_node(input in_item_t it);
    result_t     r;
    int unsigned n;
    int unsigned i;
    int unsigned idx;
    bit          found;
    r     = '0;
    found = 1'b0;
    case (it.action)
      ACT_MSG: begin
        case (it.message_kind)
          MSG_REQUEST: begin
            if (fork_st == FORK_DIRTY) begin
              fork_st       = FORK_ABSENT;
              r.send_kind   = SEND_RELEASE;
              r.send_target = it.sender_id;
            end else begin
              req_bits[it.sender_id] = 1'b1;
            end
          end
          MSG_RELEASE: fork_st = FORK_CLEAN;
          MSG_DONE: begin
            req_bits[it.sender_id] = 1'b0;
            if (done_cnt != TALLY_MAX) done_cnt = done_cnt + 1'b1;
          end
          default: begin
            if (started_cnt != TALLY_MAX) started_cnt = started_cnt + 1'b1;
          end
        endcase
      end
      ACT_ENTER: begin
        if (fork_st == FORK_DIRTY) fork_st = FORK_CLEAN;
        if (fork_st != FORK_CLEAN) r.send_kind = SEND_BCAST;
      end
      ACT_RELEASE: begin
        if (fork_st != FORK_CLEAN) begin
          r.misuse_error = 1'b1;
        end else begin
          n = (node_cnt > NODES) ? NODES : node_cnt;
          fork_st = FORK_DIRTY;
          for (i = 0; i < n && !found; i++) begin
            idx = (own_id + i) % n;
            if (req_bits[idx]) begin
              found         = 1'b1;
              req_bits      = '0;
              fork_st       = FORK_ABSENT;
              r.send_kind   = SEND_RELEASE;
              r.send_target = idx[3:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.section_granted = (fork_st == FORK_CLEAN);
    r.fork_now        = fork_st;
    r.done_seen       = done_cnt;
    r.started_seen    = started_cnt;
    return r;
  endfunction

  task automatic flag_error(input string what, input result_t exp_r, input result_t act_r);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%0t %s: exp kind %0d tgt %0d grant %0b fork %0d done %0d started %0d misuse %0b",
               $time, what, exp_r.send_kind, exp_r.send_target, exp_r.section_granted,
               exp_r.fork_now, exp_r.done_seen, exp_r.started_seen, exp_r.misuse_error);
      $display("%0t %s: got kind %0d tgt %0d grant %0b fork %0d done %0d started %0d misuse %0b",
               $time, what, act_r.send_kind, act_r.send_target, act_r.section_granted,
               act_r.fork_now, act_r.done_seen, act_r.started_seen, act_r.misuse_error);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        got = result_o;
        if (pending_results.size() == 0) begin
          flag_error("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.send_kind !== want.send_kind || got.send_target !== want.send_target ||
              got.section_granted !== want.section_granted ||
              got.fork_now !== want.fork_now || got.done_seen !== want.done_seen ||
              got.started_seen !== want.started_seen ||
              got.misuse_error !== want.misuse_error) begin
            flag_error("mismatch", want, got);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        case (cfg_index_i)
          CFG_OWN_ID:     own_id = cfg_data_i[IDX_W-1:0];
          CFG_NODE_TOTAL: node_cnt = cfg_data_i;
          CFG_STARTS_FORK: begin
            starts_fork = cfg_data_i[0];
            fork_st     = starts_fork ? FORK_DIRTY : FORK_ABSENT;
          end
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        want = step_node(in_item_i);
        if (pin_on) want = pin_res;
        if (want.send_kind == SEND_RELEASE) n_pass++;
        if (want.send_kind == SEND_BCAST) n_bcast++;
        if (want.misuse_error) n_misuse++;
        n_items++;
        pending_results.push_back(want);
      end
    end
  end

  task automatic drive_item(input in_item_t it, input int unsigned gap,
                            input bit pin, input result_t pres);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pin_on    = pin;
    pin_res   = pres;
    start_i   = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    dir_row_t    rows[$];
    dir_row_t    row;
    in_item_t    it;
    int unsigned gap_pct;
    int unsigned gap;
    int unsigned span;
    int unsigned roll;
    logic [4:0]  own_val;
    logic [4:0]  tot_val;
    logic        fork_val;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: own id 0, two nodes, fork absent
    rows.push_back(row_pin(mk_item(ACT_ENTER, MSG_STARTED, 4'd0),
                           mk_res(SEND_BCAST, 0, 0, FORK_ABSENT, 0, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_RELEASE, MSG_REQUEST, 4'd0),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 0, 0, 1)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_REQUEST, 4'd1),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 0, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_DONE, 4'd1),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 1, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_REQUEST, 4'd1),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 1, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_RELEASE, 4'd0),
                           mk_res(SEND_NONE, 0, 1, FORK_CLEAN, 1, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_REQUEST, 4'd15),
                           mk_res(SEND_NONE, 0, 1, FORK_CLEAN, 1, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_RELEASE, MSG_DONE, 4'd15),
                           mk_res(SEND_RELEASE, 1, 0, FORK_ABSENT, 1, 0, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_STARTED, 4'd9),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_UNKNOWN, MSG_STARTED, 4'd15),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_RELEASE, 4'd3),
                           mk_res(SEND_NONE, 0, 1, FORK_CLEAN, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_ENTER, MSG_REQUEST, 4'd0),
                           mk_res(SEND_NONE, 0, 1, FORK_CLEAN, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_RELEASE, MSG_REQUEST, 4'd0),
                           mk_res(SEND_NONE, 0, 0, FORK_DIRTY, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_ENTER, MSG_RELEASE, 4'd6),
                           mk_res(SEND_NONE, 0, 1, FORK_CLEAN, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_RELEASE, MSG_REQUEST, 4'd0),
                           mk_res(SEND_NONE, 0, 0, FORK_DIRTY, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_RELEASE, MSG_REQUEST, 4'd0),
                           mk_res(SEND_NONE, 0, 0, FORK_DIRTY, 1, 1, 1)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_REQUEST, 4'd15),
                           mk_res(SEND_RELEASE, 15, 0, FORK_ABSENT, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_REQUEST, 4'd0),
                           mk_res(SEND_NONE, 0, 0, FORK_ABSENT, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_MSG, MSG_RELEASE, 4'd15),
                           mk_res(SEND_NONE, 0, 1, FORK_CLEAN, 1, 1, 0)));
    rows.push_back(row_pin(mk_item(ACT_RELEASE, MSG_REQUEST, 4'd0),
                           mk_res(SEND_RELEASE, 0, 0, FORK_ABSENT, 1, 1, 0)));
    // sixteen nodes, search wraps from the top id; fork reloaded dirty
    rows.push_back(row_cfg(CFG_OWN_ID, 5'd31));
    rows.push_back(row_cfg(CFG_NODE_TOTAL, 5'd16));
    rows.push_back(row_cfg(CFG_STARTS_FORK, 5'd1));
    rows.push_back(row_item(mk_item(ACT_MSG, MSG_REQUEST, 4'd3)));
    rows.push_back(row_item(mk_item(ACT_MSG, MSG_REQUEST, 4'd14)));
    rows.push_back(row_item(mk_item(ACT_MSG, MSG_REQUEST, 4'd2)));
    rows.push_back(row_item(mk_item(ACT_MSG, MSG_RELEASE, 4'd0)));
    rows.push_back(row_item(mk_item(ACT_RELEASE, MSG_STARTED, 4'd5)));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        drive_item(row.item, gap, row.pinned, row.res);
      end
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      fork_val = 1'($urandom_range(0, 1));
      case (ph)
        0: begin own_val = 5'd0;  tot_val = 5'd2;  fork_val = 1'b1; end
        1: begin own_val = 5'd15; tot_val = 5'd16; fork_val = 1'b0; end
        2: begin own_val = 5'd4;  tot_val = 5'd0;  end
        3: begin own_val = 5'd31; tot_val = 5'd31; end
        4: begin own_val = 5'd9;  tot_val = 5'd1;  end
        5: begin own_val = 5'd16; tot_val = 5'd17; end
        default: begin
          own_val = 5'($urandom_range(0, 31));
          tot_val = 5'($urandom_range(2, 16));
        end
      endcase
      write_reg(CFG_OWN_ID, own_val);
      write_reg(CFG_NODE_TOTAL, tot_val);
      if (ph == 6) write_reg(CFG_SPARE, 5'd31);
      write_reg(CFG_STARTS_FORK, {4'($urandom_range(0, 15)), fork_val});

      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 25;
        default: gap_pct = 50;
      endcase
      if (ph == PHASES - 1) gap_pct = 0;

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        span = (node_cnt == 0 || node_cnt > NODES) ? NODES : node_cnt;
        it.sender_id = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, span - 1));
        it.message_kind = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (fork_st == FORK_CLEAN && roll < 35) it.action = ACT_RELEASE;
        else if (roll < 4)  it.action = ACT_UNKNOWN;
        else if (roll < 14) it.action = ACT_ENTER;
        else if (roll < 22) it.action = ACT_RELEASE;
        else                it.action = ACT_MSG;
        if (it.action == ACT_MSG) begin
          roll = $urandom_range(0, 99);
          if (roll < 45)      it.message_kind = MSG_REQUEST;
          else if (roll < 65) it.message_kind = MSG_RELEASE;
          else if (roll < 85) it.message_kind = MSG_DONE;
          else                it.message_kind = MSG_STARTED;
        end
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 18) : 0;
        drive_item(it, gap, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) err_cnt++;

    $display("%0d events over %0d register writes: %0d fork passes, %0d broadcasts,",
             n_items, n_cfg, n_pass, n_bcast);
    $display("%0d misused releases, %0d failures", n_misuse, err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
